@@ hw/rtl/tbsc_pkg.sv @@
// tbsc_pkg: widths, register codes, types and the shared multiply helper
// for the triangle box slab cull block
// no dependencies
package tbsc_pkg;

  localparam int COORD_W    = 20;
  localparam int AXIS_W     = 16;
  localparam int EXT_W      = 20;
  localparam int EXT_SHIFT  = 14;
  localparam int NUM_AXES   = 3;
  localparam int NUM_VTX    = 3;
  localparam int PROD_W     = AXIS_W + COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DIST_W     = SUM_W + 1;
  localparam int LIM_W      = EXT_W + EXT_SHIFT;
  localparam int AXIS_PK_W  = 3 * AXIS_W;
  localparam int PT_PK_W    = 3 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PT_PK_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_U  = 3'd0,
    REG_AXIS_V  = 3'd1,
    REG_AXIS_W  = 3'd2,
    REG_ORIGIN  = 3'd3,
    REG_EXTENTS = 3'd4
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_comp_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vtx_t;

  typedef vtx_t [NUM_VTX-1:0] tri_t;

  // per-axis constants handed to each slab test
  typedef struct packed {
    axis_comp_t               ax;
    axis_comp_t               ay;
    axis_comp_t               az;
    logic signed [SUM_W-1:0]  org;
    logic [LIM_W-1:0]         lim;
  } axis_cfg_t;

  // exact signed axis component times coordinate
  function automatic logic signed [PROD_W-1:0] mul_ac(axis_comp_t a, coord_t c);
    logic signed [PROD_W-1:0] aw;
    logic signed [PROD_W-1:0] cw;
    aw = PROD_W'(a);
    cw = PROD_W'(c);
    return aw * cw;
  endfunction

  // exact three-term dot product
  function automatic logic signed [SUM_W-1:0] dot3(axis_comp_t ax, axis_comp_t ay,
                                                   axis_comp_t az, vtx_t p);
    logic signed [SUM_W-1:0] px;
    logic signed [SUM_W-1:0] py;
    logic signed [SUM_W-1:0] pz;
    px = SUM_W'(mul_ac(ax, p.x));
    py = SUM_W'(mul_ac(ay, p.y));
    pz = SUM_W'(mul_ac(az, p.z));
    return px + py + pz;
  endfunction

endpackage

@@ hw/rtl/tbsc_if.sv @@
// tbsc_if: handshake channels of the triangle box slab cull block
// depends on tbsc_pkg
interface tbsc_tri_if import tbsc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t v0_x;
  coord_t v0_y;
  coord_t v0_z;
  coord_t v1_x;
  coord_t v1_y;
  coord_t v1_z;
  coord_t v2_x;
  coord_t v2_y;
  coord_t v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                output ready);
endinterface

interface tbsc_cfg_if import tbsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface tbsc_res_if ();
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink (input valid, culled, output ready);
endinterface

@@ hw/rtl/tbsc_cfg_regs.sv @@
// tbsc_cfg_regs: box configuration registers and registered origin projections
// depends on tbsc_pkg and tbsc_cfg_if
module tbsc_cfg_regs import tbsc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tbsc_cfg_if.sink                      cfg_i,
  output axis_cfg_t [NUM_AXES-1:0]      axis_cfg_o
);

  logic [NUM_AXES-1:0][AXIS_PK_W-1:0] axis_q;
  logic [PT_PK_W-1:0]                 origin_q;
  logic [PT_PK_W-1:0]                 ext_q;
  logic signed [SUM_W-1:0]            org_q [NUM_AXES];
  logic signed [SUM_W-1:0]            org_d [NUM_AXES];
  vtx_t                               origin;

  assign cfg_i.ready = 1'b1;
  assign origin      = vtx_t'(origin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= '0;
      origin_q <= '0;
      ext_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_AXIS_U:  axis_q[0] <= cfg_i.data[AXIS_PK_W-1:0];
        REG_AXIS_V:  axis_q[1] <= cfg_i.data[AXIS_PK_W-1:0];
        REG_AXIS_W:  axis_q[2] <= cfg_i.data[AXIS_PK_W-1:0];
        REG_ORIGIN:  origin_q  <= cfg_i.data[PT_PK_W-1:0];
        REG_EXTENTS: ext_q     <= cfg_i.data[PT_PK_W-1:0];
        default: ;
      endcase
    end
  end

  // axis . origin, registered behind the axis and origin registers
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      org_d[a] = dot3($signed(axis_q[a][AXIS_W-1:0]),
                      $signed(axis_q[a][2*AXIS_W-1:AXIS_W]),
                      $signed(axis_q[a][3*AXIS_W-1:2*AXIS_W]), origin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        org_q[a] <= '0;
      end
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        org_q[a] <= org_d[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_cfg_o[a].ax  = $signed(axis_q[a][AXIS_W-1:0]);
      axis_cfg_o[a].ay  = $signed(axis_q[a][2*AXIS_W-1:AXIS_W]);
      axis_cfg_o[a].az  = $signed(axis_q[a][3*AXIS_W-1:2*AXIS_W]);
      axis_cfg_o[a].org = org_q[a];
      axis_cfg_o[a].lim = {ext_q[a*EXT_W +: EXT_W], {EXT_SHIFT{1'b0}}};
    end
  end

endmodule

@@ hw/rtl/tbsc_axis_test.sv @@
// tbsc_axis_test: slab test of one triangle against one box axis
// depends on tbsc_pkg
module tbsc_axis_test import tbsc_pkg::*; (
  input  axis_cfg_t cfg_i,
  input  tri_t      tri_i,
  output logic      cull_o
);

  logic signed [SUM_W-1:0]  vsum  [NUM_VTX];
  logic signed [DIST_W-1:0] vdist [NUM_VTX];
  logic signed [DIST_W-1:0] lim;
  logic [NUM_VTX-1:0]       below;
  logic [NUM_VTX-1:0]       above;

  assign lim = $signed(DIST_W'(cfg_i.lim));

  always_comb begin
    for (int k = 0; k < NUM_VTX; k++) begin
      vsum[k]  = dot3(cfg_i.ax, cfg_i.ay, cfg_i.az, tri_i[k]);
      vdist[k] = DIST_W'(vsum[k]) - DIST_W'(cfg_i.org);
      below[k] = vdist[k][DIST_W-1];
      above[k] = vdist[k] > lim;
    end
  end

  // boundary distances count as inside
  assign cull_o = (&below) | (&above);

endmodule

@@ hw/rtl/triangle_box_slab_cull.sv @@
// triangle_box_slab_cull: top level, input register, three slab tests, result register
// depends on tbsc_pkg, tbsc_if, tbsc_cfg_regs and tbsc_axis_test
//
// Culls one triangle per clock against an oriented box while the result side
// keeps up. A triangle word is taken into an input register, tested against
// all three box axes in one pass of combinational logic (nine exact 16x20
// products per axis) and its culled bit lands in a result register; a new
// triangle is accepted every cycle while the result side keeps up. Two words
// can be held while the result side stalls. Box registers are written through
// the configuration channel, which is always ready; the origin projections
// are registered behind the axis and origin registers, so the user writes the
// box while no triangle is in flight; the block itself does not enforce this.
module triangle_box_slab_cull import tbsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbsc_tri_if.sink   tri_i,
  tbsc_cfg_if.sink   cfg_i,
  tbsc_res_if.source res_o
);

  axis_cfg_t [NUM_AXES-1:0] axis_cfg;
  logic [NUM_AXES-1:0]      axis_cull;
  logic                     s1_valid_q, s1_valid_d;
  tri_t                     s1_tri_q, s1_tri_d;
  logic                     res_valid_q, res_valid_d;
  logic                     culled_q, culled_d;
  logic                     res_free;
  logic                     tri_acc;

  tbsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .axis_cfg_o (axis_cfg)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    tbsc_axis_test u_axis (
      .cfg_i  (axis_cfg[a]),
      .tri_i  (s1_tri_q),
      .cull_o (axis_cull[a])
    );
  end

  assign res_free    = !res_valid_q || res_o.ready;
  assign tri_i.ready = !s1_valid_q || res_free;
  assign tri_acc     = tri_i.valid && tri_i.ready;

  always_comb begin
    s1_tri_d[0] = '{x: tri_i.v0_x, y: tri_i.v0_y, z: tri_i.v0_z};
    s1_tri_d[1] = '{x: tri_i.v1_x, y: tri_i.v1_y, z: tri_i.v1_z};
    s1_tri_d[2] = '{x: tri_i.v2_x, y: tri_i.v2_y, z: tri_i.v2_z};
    s1_valid_d  = tri_i.ready ? tri_i.valid : s1_valid_q;
    res_valid_d = res_free ? s1_valid_q : res_valid_q;
    culled_d    = |axis_cull;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tri_acc) begin
      s1_tri_q <= s1_tri_d;
    end
    if (res_free && s1_valid_q) begin
      culled_q <= culled_d;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.culled = culled_q;

endmodule

@@ hw/rtl/tbsc_checker.sv @@
// tbsc_checker: port-level assertions for the triangle box slab cull block
// depends on triangle_box_slab_cull, attached by bind
module tbsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic tri_valid_i,
  input logic tri_ready_i,
  input logic cfg_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_culled_i
);

  // no result word straight out of reset
  a_res_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  // input back-pressure only when both stages are full and the result is stalled
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tri_ready_i |-> (res_valid_i && !res_ready_i && cfg_ready_i))
    else $error("input stalled without a stalled result");

  // a triangle taken with the result side empty shows up at the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tri_valid_i && tri_ready_i && !res_valid_i) |-> ##2 res_valid_i)
    else $error("accepted triangle did not reach the result");

  a_res_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_res_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> $stable(res_culled_i))
    else $error("result word changed while stalled");

endmodule

bind triangle_box_slab_cull tbsc_checker u_tbsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tri_valid_i  (tri_i.valid),
  .tri_ready_i  (tri_i.ready),
  .cfg_ready_i  (cfg_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_culled_i (res_o.culled)
);

@@ bench/triangle_box_slab_cull_test.sv @@
// triangle_box_slab_cull_test: self-checking bench for the triangle box slab cull block
// drives triangle and box register words, predicts each culled bit and checks it in order
// depends on tbsc_pkg, tbsc_if and triangle_box_slab_cull
`timescale 1ns / 100ps

module triangle_box_slab_cull_test import tbsc_pkg::*; ();

  localparam int ONE_Q14     = 2 ** (AXIS_W - 2);
  localparam int AXIS_MIN    = -(2 ** (AXIS_W - 1));
  localparam int AXIS_MAX    = 2 ** (AXIS_W - 1) - 1;
  localparam int COORD_MIN   = -(2 ** (COORD_W - 1));
  localparam int COORD_MAX   = 2 ** (COORD_W - 1) - 1;
  localparam int EXT_MAX     = 2 ** EXT_W - 1;
  localparam int CFG_REGS    = 2 ** CFG_IDX_W;
  localparam int SETTLE_GAP  = 4;
  localparam int TAIL_GAP    = 8;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 175;
  localparam int CYCLE_LIMIT = 200000;

  class cull_ledger;
    logic [AXIS_PK_W-1:0] axis_reg [NUM_AXES];
    logic [PT_PK_W-1:0]   origin_reg;
    logic [PT_PK_W-1:0]   extents_reg;
    bit                   verdicts_due [$];
    int unsigned          mismatches;
    int unsigned          checked;

    function new();
      foreach (axis_reg[a]) axis_reg[a] = '0;
      origin_reg  = '0;
      extents_reg = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_AXIS_U:  axis_reg[0] = data[AXIS_PK_W-1:0];
        REG_AXIS_V:  axis_reg[1] = data[AXIS_PK_W-1:0];
        REG_AXIS_W:  axis_reg[2] = data[AXIS_PK_W-1:0];
        REG_ORIGIN:  origin_reg  = data[PT_PK_W-1:0];
        REG_EXTENTS: extents_reg = data[PT_PK_W-1:0];
        default: ;
      endcase
    endfunction

    function bit predict_cull(tri_t t);
      longint     comp [3];
      longint     org;
      longint     lim;
      longint     d;
      axis_comp_t ac;
      coord_t     oc;
      bit         below;
      bit         above;
      bit         cull;
      cull = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        org = 0;
        for (int i = 0; i < 3; i++) begin
          ac      = axis_reg[a][AXIS_W*i +: AXIS_W];
          oc      = origin_reg[COORD_W*i +: COORD_W];
          comp[i] = longint'(ac);
          org    += comp[i] * longint'(oc);
        end
        lim   = longint'(extents_reg[EXT_W*a +: EXT_W]) << EXT_SHIFT;
        below = 1'b1;
        above = 1'b1;
        for (int k = 0; k < NUM_VTX; k++) begin
          d = comp[0] * longint'(t[k].x) + comp[1] * longint'(t[k].y)
            + comp[2] * longint'(t[k].z) - org;
          if (!(d < 0)) below = 1'b0;
          if (!(d > lim)) above = 1'b0;
        end
        if (below || above) cull = 1'b1;
      end
      return cull;
    endfunction

    function void note_triangle(tri_t t);
      verdicts_due.push_back(predict_cull(t));
    endfunction

    function void check_verdict(logic culled);
      bit want;
      checked++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $error("culled: expected none, actual %0d", culled);
      end else begin
        want = verdicts_due.pop_front();
        if (culled !== want) begin
          mismatches++;
          $error("culled: expected %0d, actual %0d", want, culled);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tbsc_tri_if tri_ch ();
  tbsc_cfg_if cfg_ch ();
  tbsc_res_if res_ch ();

  triangle_box_slab_cull u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .tri_i  (tri_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  cull_ledger         ledger = new();
  int unsigned        triangles_sent = 0;
  int unsigned        cycle_count = 0;
  int unsigned        send_idle = 0;
  int unsigned        recv_idle = 0;
  logic [PT_PK_W-1:0] cur_origin = '0;
  logic [PT_PK_W-1:0] cur_ext = '0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic tri_t sampled_tri();
    tri_t t;
    t[0] = '{x: tri_ch.v0_x, y: tri_ch.v0_y, z: tri_ch.v0_z};
    t[1] = '{x: tri_ch.v1_x, y: tri_ch.v1_y, z: tri_ch.v1_z};
    t[2] = '{x: tri_ch.v2_x, y: tri_ch.v2_y, z: tri_ch.v2_z};
    return t;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) ledger.write_reg(cfg_ch.index, cfg_ch.data);
      if (tri_ch.valid && tri_ch.ready) ledger.note_triangle(sampled_tri());
      if (res_ch.valid && res_ch.ready) ledger.check_verdict(res_ch.culled);
    end
  end

  function automatic vtx_t vtx(int x, int y, int z);
    vtx_t v;
    v.x = COORD_W'(x);
    v.y = COORD_W'(y);
    v.z = COORD_W'(z);
    return v;
  endfunction

  function automatic tri_t make_tri(vtx_t a, vtx_t b, vtx_t c);
    return {c, b, a};
  endfunction

  function automatic logic [AXIS_PK_W-1:0] pack_axis(int x, int y, int z);
    return {AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)};
  endfunction

  function automatic logic [PT_PK_W-1:0] pack_pt(int x, int y, int z);
    return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic int unit_sign();
    return ($urandom_range(1) == 0) ? ONE_Q14 : -ONE_Q14;
  endfunction

  // coordinate near the box faces, or anywhere at all
  function automatic coord_t near_coord(int i);
    int     r;
    int     o;
    int     e;
    coord_t oc;
    r  = $urandom_range(9);
    oc = cur_origin[COORD_W*i +: COORD_W];
    o  = int'(oc);
    e  = int'(cur_ext[EXT_W*i +: EXT_W]);
    if (r < 3) return COORD_W'($urandom);
    if (r < 6) return COORD_W'(o + $urandom_range(0, 2 * e + 128) - (e / 2 + 64));
    case ($urandom_range(5))
      0: return COORD_W'(o - 1);
      1: return COORD_W'(o);
      2: return COORD_W'(o + e);
      3: return COORD_W'(o + e + 1);
      4: return COORD_W'(o - e);
      default: return COORD_W'(o - e - 1);
    endcase
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    for (int k = 0; k < NUM_VTX; k++) begin
      if (k > 0 && $urandom_range(3) == 0) begin
        t[k] = t[k-1];
      end else begin
        t[k].x = near_coord(0);
        t[k].y = near_coord(1);
        t[k].z = near_coord(2);
      end
    end
    return t;
  endfunction

  task automatic send_triangle(tri_t t);
    while ($urandom_range(99) < send_idle) begin
      tri_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tri_ch.valid <= 1'b1;
    tri_ch.v0_x  <= t[0].x;
    tri_ch.v0_y  <= t[0].y;
    tri_ch.v0_z  <= t[0].z;
    tri_ch.v1_x  <= t[1].x;
    tri_ch.v1_y  <= t[1].y;
    tri_ch.v1_z  <= t[1].z;
    tri_ch.v2_x  <= t[2].x;
    tri_ch.v2_y  <= t[2].y;
    tri_ch.v2_z  <= t[2].z;
    do @(posedge clk); while (!tri_ch.ready);
    triangles_sent++;
  endtask

  task automatic stop_triangles();
    tri_ch.valid <= 1'b0;
  endtask

  task automatic write_box_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // axis words carry random junk above the packed components
  task automatic set_box(logic [AXIS_PK_W-1:0] au, logic [AXIS_PK_W-1:0] av,
                         logic [AXIS_PK_W-1:0] aw, logic [PT_PK_W-1:0] org,
                         logic [PT_PK_W-1:0] ext);
    logic [CFG_DATA_W-1:0] junk;
    junk = rand_word();
    write_box_reg(REG_AXIS_U, {junk[CFG_DATA_W-1:AXIS_PK_W], au});
    junk = rand_word();
    write_box_reg(REG_AXIS_V, {junk[CFG_DATA_W-1:AXIS_PK_W], av});
    junk = rand_word();
    write_box_reg(REG_AXIS_W, {junk[CFG_DATA_W-1:AXIS_PK_W], aw});
    write_box_reg(REG_ORIGIN, org);
    write_box_reg(REG_EXTENTS, ext);
    cur_origin = org;
    cur_ext    = ext;
  endtask

  task automatic end_cfg();
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (ledger.checked < triangles_sent) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic random_box(int kind);
    logic [AXIS_PK_W-1:0] ax [3];
    logic [PT_PK_W-1:0]   org;
    logic [PT_PK_W-1:0]   ext;
    int                   pt [3];
    int                   ev [3];
    int                   c [3];
    org = pack_pt($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 8191) - 4096);
    ext = pack_pt($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    case (kind)
      0: begin
        ax[0] = pack_axis(unit_sign(), 0, 0);
        ax[1] = pack_axis(0, unit_sign(), 0);
        ax[2] = pack_axis(0, 0, unit_sign());
      end
      1: begin
        for (int a = 0; a < NUM_AXES; a++) ax[a] = AXIS_PK_W'(rand_word());
        ext = pack_pt($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
      end
      2: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          for (int i = 0; i < 3; i++) begin
            case ($urandom_range(3))
              0: c[i] = AXIS_MIN;
              1: c[i] = AXIS_MAX;
              2: c[i] = 0;
              default: c[i] = ONE_Q14;
            endcase
          end
          ax[a] = pack_axis(c[0], c[1], c[2]);
        end
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(2))
            0: pt[i] = COORD_MIN;
            1: pt[i] = COORD_MAX;
            default: pt[i] = 0;
          endcase
          ev[i] = ($urandom_range(1) == 0) ? 0 : EXT_MAX;
        end
        org = pack_pt(pt[0], pt[1], pt[2]);
        ext = pack_pt(ev[0], ev[1], ev[2]);
      end
      default: begin
        ax[0] = '0;
        ax[1] = pack_axis(0, unit_sign(), 0);
        ax[2] = AXIS_PK_W'(rand_word());
      end
    endcase
    set_box(ax[0], ax[1], ax[2], org, ext);
    end_cfg();
  endtask

  initial begin
    rst_n        = 1'b1;
    tri_ch.valid = 1'b0;
    tri_ch.v0_x  = '0;
    tri_ch.v0_y  = '0;
    tri_ch.v0_z  = '0;
    tri_ch.v1_x  = '0;
    tri_ch.v1_y  = '0;
    tri_ch.v1_z  = '0;
    tri_ch.v2_x  = '0;
    tri_ch.v2_y  = '0;
    tri_ch.v2_z  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    // clean falling reset edge before the first clock edge
    #1 rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // box still at reset: all axes zero, nothing may cull
    send_triangle(make_tri(vtx(COORD_MAX, COORD_MAX, COORD_MAX),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX)));
    send_triangle(make_tri(vtx(COORD_MIN, COORD_MIN, COORD_MIN),
                           vtx(COORD_MIN, COORD_MIN, COORD_MIN),
                           vtx(COORD_MIN, COORD_MIN, COORD_MIN)));
    stop_triangles();
    settle();

    // unit cube of side 256 at the origin
    set_box(pack_axis(ONE_Q14, 0, 0), pack_axis(0, ONE_Q14, 0), pack_axis(0, 0, ONE_Q14),
            pack_pt(0, 0, 0), pack_pt(256, 256, 256));
    end_cfg();
    send_triangle(make_tri(vtx(256, 256, 256), vtx(256, 256, 256), vtx(256, 256, 256)));
    send_triangle(make_tri(vtx(257, 0, 0), vtx(257, 10, 10), vtx(300, 5, 5)));
    send_triangle(make_tri(vtx(-1, 0, 0), vtx(-1, 10, 10), vtx(-50, 5, 5)));
    send_triangle(make_tri(vtx(0, 0, 0), vtx(0, 0, 0), vtx(0, 0, 0)));
    send_triangle(make_tri(vtx(-1, 10, 10), vtx(0, 10, 10), vtx(300, 10, 10)));
    send_triangle(make_tri(vtx(COORD_MIN, COORD_MIN, COORD_MIN),
                           vtx(COORD_MIN, COORD_MIN, COORD_MIN),
                           vtx(COORD_MIN, COORD_MIN, COORD_MIN)));
    send_triangle(make_tri(vtx(COORD_MAX, COORD_MAX, COORD_MAX),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX)));
    send_triangle(make_tri(vtx(10, 10, -1), vtx(20, 20, -2), vtx(30, 30, -3)));
    send_triangle(make_tri(vtx(0, 128, 256), vtx(128, 256, 0), vtx(256, 0, 128)));
    stop_triangles();
    settle();

    // extreme axes, a zero axis, extreme origin and extents, then unknown indices
    set_box(pack_axis(AXIS_MIN, AXIS_MAX, AXIS_MIN), pack_axis(AXIS_MAX, AXIS_MIN, AXIS_MAX),
            pack_axis(0, 0, 0), pack_pt(COORD_MIN, COORD_MAX, COORD_MIN),
            pack_pt(EXT_MAX, 0, EXT_MAX));
    for (int u = int'(REG_EXTENTS) + 1; u < CFG_REGS; u++) begin
      write_box_reg(CFG_IDX_W'(u), rand_word());
    end
    end_cfg();
    send_triangle(make_tri(vtx(COORD_MAX, COORD_MIN, COORD_MAX),
                           vtx(COORD_MAX, COORD_MIN, COORD_MAX),
                           vtx(COORD_MAX, COORD_MIN, COORD_MAX)));
    send_triangle(make_tri(vtx(COORD_MIN, COORD_MAX, COORD_MIN),
                           vtx(COORD_MIN, COORD_MAX, COORD_MIN),
                           vtx(COORD_MIN, COORD_MAX, COORD_MIN)));
    send_triangle(make_tri(vtx(0, 0, 0), vtx(0, 0, 0), vtx(0, 0, 0)));
    send_triangle(make_tri(vtx(COORD_MIN, COORD_MIN, COORD_MIN),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX), vtx(0, 0, 0)));
    send_triangle(make_tri(vtx(COORD_MAX, COORD_MAX, COORD_MAX),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX),
                           vtx(COORD_MAX, COORD_MAX, COORD_MAX)));
    stop_triangles();
    settle();

    // flat slab: zero extents at an offset origin
    set_box(pack_axis(ONE_Q14, 0, 0), pack_axis(0, ONE_Q14, 0), pack_axis(0, 0, ONE_Q14),
            pack_pt(100, 100, 100), pack_pt(0, 0, 0));
    end_cfg();
    send_triangle(make_tri(vtx(100, 100, 100), vtx(100, 100, 100), vtx(100, 100, 100)));
    send_triangle(make_tri(vtx(101, 100, 100), vtx(101, 100, 100), vtx(101, 100, 100)));
    send_triangle(make_tri(vtx(100, 99, 100), vtx(100, 99, 100), vtx(100, 99, 100)));
    stop_triangles();
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle = 28;
          recv_idle = 57;
        end
        1: begin
          send_idle = 57;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      random_box(seg % 4);
      repeat (SEG_ITEMS) send_triangle(random_tri());
      stop_triangles();
      settle();
    end

    recv_idle = 0;
    while (ledger.checked < triangles_sent) @(posedge clk);
    repeat (TAIL_GAP) @(posedge clk);
    if (ledger.verdicts_due.size() != 0) begin
      ledger.mismatches++;
      $error("culled: %0d expected results never arrived", ledger.verdicts_due.size());
    end
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
